[design/utf8_line_wrap_ring_assert.svh]
// Assertion macros used by the checker file.
`ifndef UTF8_LINE_WRAP_RING_ASSERT_SVH
`define UTF8_LINE_WRAP_RING_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define U8W_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequence checked in the cycle after the antecedent.
`define U8W_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/u8w_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package u8w_pkg;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_PUT    = 2'd1;
    localparam logic [1:0] ACT_COMMIT = 2'd2;

    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] LEAD4_MIN   = 8'hF0;
    localparam logic [7:0] LEAD3_MIN   = 8'hE0;
    localparam logic [7:0] LEAD2_MIN   = 8'hC2;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_TAG    = 8'h80;

    localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic load;
        logic dec;
        logic mod_start;
        logic mod_step;
        logic adr;
        logic cp_wr;
        logic put;
        logic clear;
        logic res;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] act;
        logic       ovf;
        logic       row_ok;
        logic       len_zero;
        logic       cp_last;
        logic       put_last;
        logic       mod_last;
        logic       out_free;
    } t_stat;

endpackage
`default_nettype wire

[design/u8w_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module u8w_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[design/u8w_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module u8w_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire u8w_pkg::t_stat i_stat,
    output u8w_pkg::t_cmd      o_cmd
);
    import u8w_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_CMT  = 4'd2;
    localparam logic [3:0] S_CPR  = 4'd3;
    localparam logic [3:0] S_CPW  = 4'd4;
    localparam logic [3:0] S_PUT  = 4'd5;
    localparam logic [3:0] S_MOD  = 4'd6;
    localparam logic [3:0] S_ADR  = 4'd7;
    localparam logic [3:0] S_RD   = 4'd8;
    localparam logic [3:0] S_RES  = 4'd9;

    logic [3:0] r_state, n_state;
    logic       r_then_put, n_then_put;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_then_put = r_then_put;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                case (i_stat.op)
                    OP_APPEND: begin
                        o_cmd.dec = 1'b1;
                        case (i_stat.act)
                            ACT_COMMIT: begin
                                n_then_put = 1'b0;
                                n_state    = S_CMT;
                            end
                            ACT_PUT: begin
                                n_then_put = i_stat.ovf;
                                n_state    = i_stat.ovf ? S_CMT : S_PUT;
                            end
                            default: n_state = S_RES;
                        endcase
                    end
                    OP_READ: begin
                        if (i_stat.row_ok) begin
                            o_cmd.mod_start = 1'b1;
                            n_state         = S_MOD;
                        end else begin
                            n_state = S_RES;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_RES;
                    end
                    default: n_state = S_RES;
                endcase
            end
            S_CMT: begin
                if (i_stat.len_zero) begin
                    n_state = r_then_put ? S_PUT : S_RES;
                end else begin
                    n_state = S_CPR;
                end
            end
            S_CPR: n_state = S_CPW;
            S_CPW: begin
                o_cmd.cp_wr = 1'b1;
                if (i_stat.cp_last) begin
                    n_state = r_then_put ? S_PUT : S_RES;
                end else begin
                    n_state = S_CPR;
                end
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                if (i_stat.put_last) begin
                    n_state = S_RES;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_last) begin
                    n_state = S_ADR;
                end
            end
            S_ADR: begin
                o_cmd.adr = 1'b1;
                n_state   = S_RD;
            end
            S_RD: n_state = S_RES;
            S_RES: begin
                if (i_stat.out_free) begin
                    o_cmd.res = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_then_put <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_then_put <= n_then_put;
        end
    end
endmodule
`default_nettype wire

[design/u8w_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module u8w_dp #(
    parameter int LINE_BYTES = 64,
    parameter int RING_LINES = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire u8w_pkg::t_cmd i_cmd,
    output u8w_pkg::t_stat     o_stat,
    input  wire logic [1:0]    i_op,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_last,
    input  wire logic [23:0]   i_row,
    input  wire logic [5:0]    i_col,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output logic [7:0]         o_read_byte,
    output logic               o_read_valid,
    output logic [23:0]        o_lines_total,
    output logic [6:0]         o_current_fill
);
    import u8w_pkg::*;

    localparam int LW = $clog2(LINE_BYTES + 1);
    localparam int CW = $clog2(LINE_BYTES);
    localparam int SW = (RING_LINES > 1) ? $clog2(RING_LINES) : 1;
    localparam int AW = $clog2(RING_LINES * LINE_BYTES);
    localparam int RL = $clog2(RING_LINES);
    localparam int QS = 24 + RL;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << QS) + 64'(RING_LINES) - 64'd1) / 64'(RING_LINES);
    localparam logic [24:0] RECIP = RECIP_FULL[24:0];

    function automatic logic [2:0] char_size(input logic [7:0] lead);
        if (lead >= LEAD4_MIN) return 3'd4;
        if (lead >= LEAD3_MIN) return 3'd3;
        if (lead >= LEAD2_MIN) return 3'd2;
        return 3'd1;
    endfunction

    logic [1:0]    r_op;
    logic [7:0]    r_byte;
    logic          r_last;
    logic [23:0]   r_row;
    logic [5:0]    r_col;
    logic [LW-1:0] r_len;
    logic [23:0]   r_total;
    logic [SW-1:0] r_wslot;
    logic [AW-1:0] r_wbase;
    logic [7:0]    r_pend [3];
    logic [1:0]    r_pcnt;
    logic [2:0]    r_pneed;
    logic [7:0]    r_buf [4];
    logic [2:0]    r_n;
    logic [1:0]    r_k;
    logic [CW-1:0] r_idx;
    logic [SW-1:0] r_rem;
    logic [23:0]   r_quot;
    logic [AW-1:0] r_saddr;

    logic [7:0]    d_buf [4];
    logic [7:0]    d_pend [3];
    logic [2:0]    d_n;
    logic [1:0]    d_pcnt;
    logic [2:0]    d_pneed;
    logic [1:0]    d_act;
    logic          fresh;
    logic          cont;

    logic [7:0]    cur_q;
    logic [7:0]    store_q;
    logic [LW-1:0] len_q;
    logic          cp_last;
    logic          put_last;
    logic          rd_ok;
    logic [48:0]   quot_prod;
    logic [35:0]   quot_back;
    logic [SW+9:0] prod;

    assign cont = ((r_byte & CONT_MASK) == CONT_TAG);

    // UTF-8 collection and byte classification
    always_comb begin
        d_buf   = '{r_pend[0], r_pend[1], r_pend[2], 8'h00};
        d_pend  = r_pend;
        d_n     = 3'd1;
        d_pcnt  = r_pcnt;
        d_pneed = r_pneed;
        d_act   = ACT_NONE;
        fresh   = 1'b1;
        if (r_pneed != 3'd0) begin
            d_pcnt  = 2'd0;
            d_pneed = 3'd0;
            if (cont) begin
                fresh          = 1'b0;
                d_buf[r_pcnt]  = r_byte;
                d_n            = {1'b0, r_pcnt} + 3'd1;
                if ((d_n >= r_pneed) || r_last) begin
                    d_act = ACT_PUT;
                end else begin
                    d_pend[r_pcnt] = r_byte;
                    d_pcnt         = d_n[1:0];
                    d_pneed        = r_pneed;
                end
            end
        end
        if (fresh) begin
            if (r_byte == CH_LF) begin
                d_act = ACT_COMMIT;
            end else if ((r_byte < CH_SPACE) || cont) begin
                d_act = ACT_NONE;
            end else if ((char_size(r_byte) > 3'd1) && !r_last) begin
                d_pend[0] = r_byte;
                d_pcnt    = 2'd1;
                d_pneed   = char_size(r_byte);
            end else begin
                d_act    = ACT_PUT;
                d_buf[0] = r_byte;
                d_n      = 3'd1;
            end
        end
    end

    assign cp_last  = ((LW'(r_idx) + LW'(1)) == r_len);
    assign put_last = (({1'b0, r_k} + 3'd1) == r_n);
    assign rd_ok    = (r_row < r_total);
    // row mod RING_LINES by reciprocal multiplication: quotient first, then remainder
    assign quot_prod = 49'(r_row) * 49'(RECIP);
    assign quot_back = 36'(r_quot) * 36'(RING_LINES);
    assign prod     = (SW + 10)'(r_rem * LINE_BYTES) + (SW + 10)'(r_col);

    always_comb begin
        o_stat          = '0;
        o_stat.op       = r_op;
        o_stat.act      = d_act;
        o_stat.ovf      = (({1'b0, r_len} + (LW + 1)'(d_n)) > (LW + 1)'(LINE_BYTES));
        o_stat.row_ok   = rd_ok;
        o_stat.len_zero = (r_len == '0);
        o_stat.cp_last  = cp_last;
        o_stat.put_last = put_last;
        o_stat.mod_last = 1'b1;
        o_stat.out_free = !o_out_valid || i_out_ready;
    end

    u8w_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_cur (
        .i_clk   (i_clk),
        .i_we    (i_cmd.put),
        .i_waddr (CW'(r_len + LW'(r_k))),
        .i_wdata (r_buf[r_k]),
        .i_raddr (r_idx),
        .o_rdata (cur_q)
    );

    u8w_ram #(.WIDTH(8), .DEPTH(RING_LINES * LINE_BYTES)) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.cp_wr),
        .i_waddr (r_wbase + AW'(r_idx)),
        .i_wdata (cur_q),
        .i_raddr (r_saddr),
        .o_rdata (store_q)
    );

    u8w_ram #(.WIDTH(LW), .DEPTH(RING_LINES)) u_len (
        .i_clk   (i_clk),
        .i_we    (i_cmd.cp_wr && cp_last),
        .i_waddr (r_wslot),
        .i_wdata (r_len),
        .i_raddr (r_rem),
        .o_rdata (len_q)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_byte <= i_byte;
            r_last <= i_last;
            r_row  <= i_row;
            r_col  <= i_col;
        end
        if (i_cmd.dec) begin
            r_buf  <= d_buf;
            r_n    <= d_n;
            r_pend <= d_pend;
            r_k    <= 2'd0;
            r_idx  <= '0;
        end
        if (i_cmd.put && !put_last) begin
            r_k <= r_k + 2'd1;
        end
        if (i_cmd.cp_wr) begin
            r_idx <= cp_last ? '0 : r_idx + CW'(1);
        end
        if (i_cmd.mod_start) begin
            r_quot <= 24'(quot_prod >> QS);
        end
        if (i_cmd.mod_step) begin
            r_rem <= SW'(36'(r_row) - quot_back);
        end
        if (i_cmd.adr) begin
            r_saddr <= AW'(prod);
        end
        if (i_cmd.res) begin
            o_read_valid   <= (r_op == OP_READ) && rd_ok;
            o_read_byte    <= ((r_op == OP_READ) && rd_ok && (32'(r_col) < 32'(len_q))
                              && (32'(r_col) < LINE_BYTES)) ? store_q : 8'h00;
            o_lines_total  <= r_total;
            o_current_fill <= 7'(r_len);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_total     <= '0;
            r_wslot     <= '0;
            r_wbase     <= '0;
            r_pcnt      <= 2'd0;
            r_pneed     <= 3'd0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.dec) begin
                r_pcnt  <= d_pcnt;
                r_pneed <= d_pneed;
            end
            if (i_cmd.put && put_last) begin
                r_len <= r_len + LW'(r_n);
            end
            if (i_cmd.cp_wr && cp_last) begin
                r_len   <= '0;
                r_total <= r_total + 24'd1;
                if ((r_wslot == SW'(RING_LINES - 1)) || (r_total == COUNT_MAX)) begin
                    r_wslot <= '0;
                    r_wbase <= '0;
                end else begin
                    r_wslot <= r_wslot + SW'(1);
                    r_wbase <= r_wbase + AW'(LINE_BYTES);
                end
            end
            if (i_cmd.clear) begin
                r_len   <= '0;
                r_total <= '0;
                r_wslot <= '0;
                r_wbase <= '0;
                r_pcnt  <= 2'd0;
                r_pneed <= 3'd0;
            end
            if (i_cmd.res) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

[design/utf8_line_wrap_ring.sv]
`timescale 1ns / 1ps
`default_nettype none
// UTF-8 aware line wrapper with a ring of stored lines. Each input transfer
// carries one command: append a text byte, read a byte of a stored line, or
// clear all lines; each command returns exactly one result transfer with the
// read byte, its row-valid flag, the committed line count and the fill of the
// unfinished line. Control bytes are dropped, LF ends a line, multi-byte
// characters are collected and never split across lines, and a character
// that does not fit first commits the current line into slot
// (line count mod RING_LINES). Work is one command at a time: an append decodes
// the byte and then puts each byte of the character it places into the line
// buffer, and a line commit copies the committed line byte by byte, with a
// read state and a write state per byte, through the single read port of the
// line buffer; a read of a valid row runs the two-step reciprocal reduction of
// the row number modulo RING_LINES and the registered reads of the ring; a read
// of an invalid row, a clear or the unused opcode goes from decode straight to
// the result. The result is loaded once the output is free, and it sits in an
// output register, so the next command is taken while it waits.
module utf8_line_wrap_ring #(
    parameter int LINE_BYTES = 64,
    parameter int RING_LINES = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] in_byte, [31:8] read_row, [37:32] read_column, [39:38] zero
    input  wire logic [39:0] s_axis_tdata,
    // [1:0] opcode
    input  wire logic [1:0]  s_axis_tuser,
    // chunk_end
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] read_byte, [31:8] lines_total, [38:32] current_fill, [39] zero
    output logic [39:0]      m_axis_tdata,
    // [0] read_valid
    output logic             m_axis_tuser
);
    import u8w_pkg::*;

    t_cmd        cmd;
    t_stat       stat;
    logic [7:0]  read_byte;
    logic [23:0] lines_total;
    logic [6:0]  current_fill;

    u8w_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    u8w_dp #(.LINE_BYTES(LINE_BYTES), .RING_LINES(RING_LINES)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_op           (s_axis_tuser),
        .i_byte         (s_axis_tdata[7:0]),
        .i_last         (s_axis_tlast),
        .i_row          (s_axis_tdata[31:8]),
        .i_col          (s_axis_tdata[37:32]),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_read_byte    (read_byte),
        .o_read_valid   (m_axis_tuser),
        .o_lines_total  (lines_total),
        .o_current_fill (current_fill)
    );

    // pack the result transfer, lowest field first
    assign m_axis_tdata = {1'b0, current_fill, lines_total, read_byte};
endmodule
`default_nettype wire

[design/u8w_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module u8w_checker #(
    parameter int LINE_BYTES = 64
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);
`include "utf8_line_wrap_ring_assert.svh"

    // a stalled result holds its payload
    `U8W_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // one command at a time: no second transfer right after one is taken
    `U8W_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // an invalid row reads back as zero
    `U8W_ASSERT_IMPLY(a_invalid_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[7:0] == 8'h00)

    // the unfinished line never exceeds the buffer
    `U8W_ASSERT_IMPLY(a_fill_bound, i_clk, i_rst_n, m_axis_tvalid, 32'(m_axis_tdata[38:32]) <= LINE_BYTES)
endmodule

bind utf8_line_wrap_ring u8w_checker #(.LINE_BYTES(LINE_BYTES)) u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
